### rtl/ehc_pkg.sv
package ehc_pkg;

	localparam int unsigned OFF_W = 6;
	localparam int unsigned CNT_W = OFF_W + 1;
	localparam logic [OFF_W-1:0] OFF_MAX = '1;

	// Ethertypes
	localparam logic [15:0] ETH_ARP  = 16'h0806;
	localparam logic [15:0] ETH_RARP = 16'h8035;
	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_PUB  = 16'h0200;

	// IP protocol numbers
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	// Byte offsets of the captured fields
	localparam logic [OFF_W-1:0] OFF_SRC_MAC  = 6'd6;
	localparam logic [OFF_W-1:0] OFF_ETYPE    = 6'd12;
	localparam logic [OFF_W-1:0] OFF_L3       = 6'd14;
	localparam logic [OFF_W-1:0] OFF_PROTO    = 6'd23;
	localparam logic [OFF_W-1:0] OFF_IP_SRC   = 6'd26;
	localparam logic [OFF_W-1:0] OFF_IP_DST   = 6'd30;
	localparam logic [OFF_W-1:0] OFF_PORTS    = 6'd34;
	localparam logic [OFF_W-1:0] OFF_ARP_TGT  = 6'd38;
	localparam logic [OFF_W-1:0] OFF_END      = 6'd42;

	// Minimum frame length per class
	localparam logic [CNT_W-1:0] NEED_ETH  = 7'd14;
	localparam logic [CNT_W-1:0] NEED_IPV4 = 7'd24;
	localparam logic [CNT_W-1:0] NEED_ICMP = 7'd34;
	localparam logic [CNT_W-1:0] NEED_L4   = 7'd38;
	localparam logic [CNT_W-1:0] NEED_ARP  = 7'd42;

	typedef enum logic [2:0] {
		CLS_ARP   = 3'd0,
		CLS_RARP  = 3'd1,
		CLS_ICMP  = 3'd2,
		CLS_TCP   = 3'd3,
		CLS_UDP   = 3'd4,
		CLS_IPV4  = 3'd5,
		CLS_PUB   = 3'd6,
		CLS_OTHER = 3'd7
	} pkt_class_t;

	typedef struct packed {
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] ethertype;
		logic [7:0]  ip_proto;
		logic [31:0] ipv4_src;
		logic [31:0] ipv4_dst;
		logic [31:0] ports;
		logic [31:0] arp_target;
	} fields_t;

	typedef struct packed {
		logic        too_short;
		logic        port_valid;
		logic [15:0] dst_port;
		logic [15:0] src_port;
		logic        addr_valid;
		logic [31:0] dst_ip;
		logic [31:0] src_ip;
		pkt_class_t  packet_class;
		logic [47:0] src_mac;
		logic [47:0] dst_mac;
	} result_t;

endpackage

### rtl/ehc_capture.sv
module ehc_capture (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  logic [7:0]             frame_byte,
	input  logic                   last_byte,
	output ehc_pkg::fields_t       fld,
	output logic [ehc_pkg::CNT_W-1:0] count
);
	import ehc_pkg::*;

	logic [OFF_W-1:0] off_q;
	fields_t          fld_q;
	fields_t          fld_nxt;

	// shift the byte into whichever field owns this offset
	always_comb begin
		fld_nxt = fld_q;
		if (off_q < OFF_SRC_MAC) begin
			fld_nxt.dst_mac = {fld_q.dst_mac[39:0], frame_byte};
		end else if (off_q < OFF_ETYPE) begin
			fld_nxt.src_mac = {fld_q.src_mac[39:0], frame_byte};
		end else if (off_q < OFF_L3) begin
			fld_nxt.ethertype = {fld_q.ethertype[7:0], frame_byte};
		end else if (off_q == OFF_PROTO) begin
			fld_nxt.ip_proto = frame_byte;
		end else if (off_q >= OFF_IP_SRC && off_q < OFF_IP_DST) begin
			fld_nxt.ipv4_src = {fld_q.ipv4_src[23:0], frame_byte};
		end else if (off_q >= OFF_IP_DST && off_q < OFF_PORTS) begin
			fld_nxt.ipv4_dst = {fld_q.ipv4_dst[23:0], frame_byte};
		end else if (off_q >= OFF_PORTS && off_q < OFF_ARP_TGT) begin
			fld_nxt.ports = {fld_q.ports[23:0], frame_byte};
		end else if (off_q >= OFF_ARP_TGT && off_q < OFF_END) begin
			fld_nxt.arp_target = {fld_q.arp_target[23:0], frame_byte};
		end
	end

	assign fld   = fld_nxt;
	assign count = {1'b0, off_q} + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			fld_q <= '0;
		end else if (fire) begin
			if (last_byte) begin
				off_q <= '0;
				fld_q <= '0;
			end else begin
				fld_q <= fld_nxt;
				if (off_q != OFF_MAX) begin
					off_q <= off_q + OFF_W'(1);
				end
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_byte |=> off_q == '0 && fld_q == '0)
		else $error("capture state not cleared after last beat");

	a_offset_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !last_byte && off_q != OFF_MAX |=> off_q == $past(off_q) + OFF_W'(1))
		else $error("byte offset did not advance");

	a_offset_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(off_q))
		else $error("byte offset moved without a beat");

endmodule

### rtl/ehc_classify.sv
module ehc_classify (
	input  ehc_pkg::fields_t          fld,
	input  logic [ehc_pkg::CNT_W-1:0] count,
	output ehc_pkg::result_t          res
);
	import ehc_pkg::*;

	logic [CNT_W-1:0] need;

	always_comb begin
		res            = '0;
		res.dst_mac    = fld.dst_mac;
		res.src_mac    = fld.src_mac;
		res.packet_class = CLS_OTHER;
		need           = NEED_ETH;
		case (fld.ethertype)
			ETH_ARP: begin
				res.packet_class = CLS_ARP;
				need           = NEED_ARP;
				res.addr_valid = 1'b1;
				// ARP sender address sits at bytes 28-31, across the two IPv4 words
				res.src_ip     = {fld.ipv4_src[15:0], fld.ipv4_dst[31:16]};
				res.dst_ip     = fld.arp_target;
			end
			ETH_RARP: res.packet_class = CLS_RARP;
			ETH_PUB:  res.packet_class = CLS_PUB;
			ETH_IPV4: begin
				need = NEED_IPV4;
				res.packet_class = CLS_IPV4;
				if (fld.ip_proto == PROTO_ICMP) begin
					res.packet_class = CLS_ICMP;
					need           = NEED_ICMP;
					res.addr_valid = 1'b1;
				end else if (fld.ip_proto == PROTO_TCP || fld.ip_proto == PROTO_UDP) begin
					res.packet_class = (fld.ip_proto == PROTO_TCP) ? CLS_TCP : CLS_UDP;
					need           = NEED_L4;
					res.addr_valid = 1'b1;
					res.port_valid = 1'b1;
					res.src_port   = fld.ports[31:16];
					res.dst_port   = fld.ports[15:0];
				end
				if (res.addr_valid) begin
					res.src_ip = fld.ipv4_src;
					res.dst_ip = fld.ipv4_dst;
				end
			end
			default: res.packet_class = CLS_OTHER;
		endcase
		res.too_short = (count < need);
	end

endmodule

### rtl/ethernet_header_classifier.sv
// Path: a frame's last beat passes the input register, then the result register, then shows on m_*.
// Throughput: one byte beat per cycle; s_tready drops only while a finished result
//   waits in the output register and the beat in the input register is a last beat.
// Reset (arst_n low, asynchronous): input and output registers empty, byte offset and
//   every captured header field cleared to zero.
module ethernet_header_classifier (
	input  logic         clk,
	input  logic         arst_n,
	// input byte stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] frame_byte
	input  logic         s_tlast,  // last_byte
	// classification result, one beat per frame
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [199:0] m_tdata,  // [47:0] dst_mac, [95:48] src_mac, [127:96] src_ip,
	                               // [159:128] dst_ip, [160] addr_valid, [176:161] src_port,
	                               // [192:177] dst_port, [193] port_valid, [194] too_short,
	                               // [199:195] zero
	output logic [2:0]   m_tuser   // [2:0] packet_class
);
	import ehc_pkg::*;

	// input register
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	// result register
	logic             res_valid_q;
	result_t          res_q;

	logic             adv;       // beat in the input register moves on this cycle
	logic             fire;
	fields_t          fld;
	logic [CNT_W-1:0] count;
	result_t          res;

	// Only a last beat produces a result, so only a last beat can be held up
	// by a full result register that the sink is not draining.
	assign adv      = !(last_s1 && res_valid_q && !m_tready);
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// field capture and byte offset; hands back fields with the current byte merged
	ehc_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.frame_byte (byte_s1),
		.last_byte  (last_s1),
		.fld        (fld),
		.count      (count)
	);

	// class decode, field selection and length check
	ehc_classify u_classify (
		.fld   (fld),
		.count (count),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tuser  = res_q.packet_class;
	assign m_tdata  = {5'b0, res_q.too_short, res_q.port_valid, res_q.dst_port,
		res_q.src_port, res_q.addr_valid, res_q.dst_ip, res_q.src_ip,
		res_q.src_mac, res_q.dst_mac};

	a_port_implies_addr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.port_valid |-> res_q.addr_valid)
		else $error("port_valid without addr_valid");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.addr_valid |-> res_q.src_ip == '0 && res_q.dst_ip == '0)
		else $error("addresses not zero when invalid");

	a_ports_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.port_valid |-> res_q.src_port == '0 && res_q.dst_port == '0)
		else $error("ports not zero when invalid");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !m_tready |=> res_valid_q && $stable(res_q))
		else $error("pending result overwritten");

endmodule

### verif/ethernet_header_classifier_tb.sv
`timescale 1ns / 1ps

module ethernet_header_classifier_tb;
	import ehc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_BYTES  = 40;
	localparam int PHASE_FRAMES = 2;

	typedef enum {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

	// one frame: header fields forced over a fill pattern
	typedef struct {
		bit          set_hdr;
		logic [15:0] etype;
		logic [7:0]  proto;
		int          len;
		fill_t       fill;
		bit          typed;
		result_t     known;
	} frame_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [199:0] m_tdata;
	logic [2:0]   m_tuser;

	// predictor state
	fields_t        cap;
	logic [OFF_W-1:0] cap_pos;

	result_t    pending_headers[$];
	frame_row_t frame_rows[$];
	int         error_count;
	int         cycles;
	int         bytes_sent;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         hold_asks;
	int         hold_done;
	int         hold_left;

	ethernet_header_classifier u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// One accepted byte through the parser; returns 1 with the header on the last byte.
	function automatic bit predict_header_byte(input logic [7:0] b, input logic l,
			output result_t r);
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] need;
		logic             av;
		logic             pv;
		count = {1'b0, cap_pos} + 1'b1;
		r = '0;
		if (cap_pos < OFF_SRC_MAC) cap.dst_mac = {cap.dst_mac[39:0], b};
		else if (cap_pos < OFF_ETYPE) cap.src_mac = {cap.src_mac[39:0], b};
		else if (cap_pos < OFF_L3) cap.ethertype = {cap.ethertype[7:0], b};
		else if (cap_pos == OFF_PROTO) cap.ip_proto = b;
		else if (cap_pos >= OFF_IP_SRC && cap_pos < OFF_IP_DST)
			cap.ipv4_src = {cap.ipv4_src[23:0], b};
		else if (cap_pos >= OFF_IP_DST && cap_pos < OFF_PORTS)
			cap.ipv4_dst = {cap.ipv4_dst[23:0], b};
		else if (cap_pos >= OFF_PORTS && cap_pos < OFF_ARP_TGT)
			cap.ports = {cap.ports[23:0], b};
		else if (cap_pos >= OFF_ARP_TGT && cap_pos < OFF_END)
			cap.arp_target = {cap.arp_target[23:0], b};
		if (cap_pos != OFF_MAX) cap_pos++;
		if (!l) return 1'b0;

		r.dst_mac = cap.dst_mac;
		r.src_mac = cap.src_mac;
		need = NEED_ETH;
		av = 1'b0;
		pv = 1'b0;
		if (cap.ethertype == ETH_ARP) begin
			r.packet_class = CLS_ARP;
			need = NEED_ARP;
			av = 1'b1;
			// sender protocol address straddles the two IPv4 words
			r.src_ip = {cap.ipv4_src[15:0], cap.ipv4_dst[31:16]};
			r.dst_ip = cap.arp_target;
		end else if (cap.ethertype == ETH_RARP) begin
			r.packet_class = CLS_RARP;
		end else if (cap.ethertype == ETH_IPV4) begin
			need = NEED_IPV4;
			if (cap.ip_proto == PROTO_ICMP) begin
				r.packet_class = CLS_ICMP;
				need = NEED_ICMP;
				av = 1'b1;
			end else if (cap.ip_proto == PROTO_TCP || cap.ip_proto == PROTO_UDP) begin
				r.packet_class = (cap.ip_proto == PROTO_TCP) ? CLS_TCP : CLS_UDP;
				need = NEED_L4;
				av = 1'b1;
				pv = 1'b1;
				r.src_port = cap.ports[31:16];
				r.dst_port = cap.ports[15:0];
			end else begin
				r.packet_class = CLS_IPV4;
			end
			if (av) begin
				r.src_ip = cap.ipv4_src;
				r.dst_ip = cap.ipv4_dst;
			end
		end else if (cap.ethertype == ETH_PUB) begin
			r.packet_class = CLS_PUB;
		end else begin
			r.packet_class = CLS_OTHER;
		end
		r.addr_valid = av;
		r.port_valid = pv;
		r.too_short  = (count < need);
		cap = '0;
		cap_pos = '0;
		return 1'b1;
	endfunction

	// header with both MACs equal, the given class and too_short flag, and nothing else set
	function automatic result_t plain_header(input logic [47:0] mac, input pkt_class_t cls,
			input logic short_frame);
		result_t r;
		r = '0;
		r.dst_mac = mac;
		r.src_mac = mac;
		r.packet_class = cls;
		r.too_short = short_frame;
		return r;
	endfunction

	function automatic frame_row_t random_frame();
		frame_row_t fr;
		pkt_class_t cls;
		int need;
		fr.set_hdr = 1'b1;
		fr.proto = 8'($urandom_range(255));
		fr.etype = 16'($urandom_range(16'hFFFF));
		fr.fill = FILL_RAND;
		fr.typed = 1'b0;
		fr.known = '0;
		if ($urandom_range(99) < 15) begin
			// noise: no header forced
			fr.set_hdr = 1'b0;
			fr.len = $urandom_range(1, 70);
			return fr;
		end
		cls = pkt_class_t'($urandom_range(7));
		need = NEED_ETH;
		case (cls)
			CLS_ARP: begin
				fr.etype = ETH_ARP;
				need = NEED_ARP;
			end
			CLS_RARP: fr.etype = ETH_RARP;
			CLS_ICMP: begin
				fr.etype = ETH_IPV4;
				fr.proto = PROTO_ICMP;
				need = NEED_ICMP;
			end
			CLS_TCP, CLS_UDP: begin
				fr.etype = ETH_IPV4;
				fr.proto = (cls == CLS_TCP) ? PROTO_TCP : PROTO_UDP;
				need = NEED_L4;
			end
			CLS_IPV4: begin
				fr.etype = ETH_IPV4;
				need = NEED_IPV4;
			end
			CLS_PUB: fr.etype = ETH_PUB;
			default: ;
		endcase
		// mostly around the class boundary, sometimes anywhere
		if ($urandom_range(7) == 0) fr.len = $urandom_range(1, 70);
		else fr.len = need - 2 + $urandom_range(6);
		return fr;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l, output bit got,
			output result_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		got = predict_header_byte(b, l, r);
	endtask

	task automatic send_frame(input frame_row_t fr);
		logic [7:0] b;
		bit         got;
		result_t    r;
		for (int i = 0; i < fr.len; i++) begin
			case (fr.fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default:   b = 8'($urandom_range(255));
			endcase
			if (fr.set_hdr) begin
				if (i == OFF_ETYPE) b = fr.etype[15:8];
				else if (i == OFF_ETYPE + 1) b = fr.etype[7:0];
				else if (i == OFF_PROTO) b = fr.proto;
			end
			send_byte(b, i == fr.len - 1, got, r);
			bytes_sent++;
		end
		if (fr.typed) r = fr.known;
		pending_headers.push_back(r);
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// result side
	initial begin
		result_t want;
		result_t got;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = '0;
				got.dst_mac      = m_tdata[47:0];
				got.src_mac      = m_tdata[95:48];
				got.src_ip       = m_tdata[127:96];
				got.dst_ip       = m_tdata[159:128];
				got.addr_valid   = m_tdata[160];
				got.src_port     = m_tdata[176:161];
				got.dst_port     = m_tdata[192:177];
				got.port_valid   = m_tdata[193];
				got.too_short    = m_tdata[194];
				got.packet_class = pkt_class_t'(m_tuser);
				if (pending_headers.size() == 0) begin
					$display("%0t: unexpected beat: expected none, actual class %0d dst_mac %0h",
						$time, m_tuser, got.dst_mac);
					error_count++;
				end else begin
					want = pending_headers.pop_front();
					check_field("dst_mac", want.dst_mac, got.dst_mac);
					check_field("src_mac", want.src_mac, got.src_mac);
					check_field("packet_class", want.packet_class, got.packet_class);
					check_field("src_ip", want.src_ip, got.src_ip);
					check_field("dst_ip", want.dst_ip, got.dst_ip);
					check_field("addr_valid", want.addr_valid, got.addr_valid);
					check_field("src_port", want.src_port, got.src_port);
					check_field("dst_port", want.dst_port, got.dst_port);
					check_field("port_valid", want.port_valid, got.port_valid);
					check_field("too_short", want.too_short, got.too_short);
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		m_tready <= 1'b0;
		hold_done = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_asks != hold_done) begin
				hold_done = hold_asks;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t: timeout with %0d results outstanding", $time,
					pending_headers.size());
				$display("ethernet_header_classifier verification failed");
				$finish;
			end
		end
	end

	initial begin
		int phase_bytes;
		int phase_frames;
		error_count = 0;
		bytes_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_asks = 0;
		cap = '0;
		cap_pos = '0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tlast  <= 1'b0;

		// set_hdr, ethertype, proto, length, fill, typed, known header
		frame_rows.push_back('{0, 16'h0000, 8'h00, 1, FILL_ZERO, 1,
			plain_header(48'h0, CLS_OTHER, 1'b1)});
		frame_rows.push_back('{0, 16'h0000, 8'h00, 70, FILL_ONES, 1,
			plain_header('1, CLS_OTHER, 1'b0)});
		frame_rows.push_back('{0, 16'h0000, 8'h00, 14, FILL_ZERO, 1,
			plain_header(48'h0, CLS_OTHER, 1'b0)});
		frame_rows.push_back('{1, ETH_IPV4, 8'h00, 23, FILL_ZERO, 1,
			plain_header(48'h0, CLS_IPV4, 1'b1)});
		frame_rows.push_back('{1, 16'h0000, 8'h00, 15, FILL_ONES, 1,
			plain_header('1, CLS_OTHER, 1'b0)});
		frame_rows.push_back('{1, ETH_ARP, 8'h00, 42, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_ARP, 8'h00, 41, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_ARP, 8'h00, 42, FILL_ONES, 0, '0});
		frame_rows.push_back('{1, ETH_ARP, 8'h00, 70, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_RARP, 8'h00, 14, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_RARP, 8'h00, 13, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_IPV4, PROTO_ICMP, 34, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_IPV4, PROTO_ICMP, 33, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_IPV4, PROTO_TCP, 38, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_IPV4, PROTO_TCP, 37, FILL_ONES, 0, '0});
		frame_rows.push_back('{1, ETH_IPV4, PROTO_UDP, 38, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_IPV4, PROTO_UDP, 64, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_IPV4, 8'hFF, 24, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_IPV4, 8'h00, 30, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_PUB, 8'h00, 14, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, ETH_PUB, 8'h00, 12, FILL_RAND, 0, '0});
		frame_rows.push_back('{1, 16'hFFFF, 8'h00, 20, FILL_RAND, 0, '0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (frame_rows[i]) send_frame(frame_rows[i]);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 73;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 73;
				end
				default: begin
					send_idle_pct = 12;
					recv_stall_pct = 12;
				end
			endcase
			phase_bytes = bytes_sent;
			phase_frames = 0;
			if (phase == 0) begin
				// long output hold-off: short frames back up into the input side
				hold_asks <= hold_asks + 1;
				repeat (24) begin
					frame_rows[0] = random_frame();
					frame_rows[0].len = $urandom_range(1, 3);
					send_frame(frame_rows[0]);
					phase_frames++;
				end
			end
			while (bytes_sent - phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
				send_frame(random_frame());
				phase_frames++;
			end
		end
		s_tvalid <= 1'b0;

		while (pending_headers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("ethernet_header_classifier verification clean");
		end else begin
			$display("ethernet_header_classifier verification failed");
		end
		$finish;
	end

endmodule

### sim.f
rtl/ehc_pkg.sv
rtl/ehc_capture.sv
rtl/ehc_classify.sv
rtl/ethernet_header_classifier.sv
verif/ethernet_header_classifier_tb.sv
